/* src/bks_pkg.sv */
// ----------------------------------------------------------------------------
// bks_pkg: shared types and constants for the banner keyword scanner
// Keyword table, limits and the input item type used by every stage.
// ----------------------------------------------------------------------------
package bks_pkg;

  localparam int MAX_BANNER_BYTES = 255;
  localparam int KEYWORD_COUNT    = 8;
  localparam int WINDOW_BYTES     = 13;

  localparam int KW_TOTAL   = 8;
  localparam int KW_MAX     = 13;
  localparam int HIST_DEPTH = WINDOW_BYTES - 1;
  localparam int CNT_W      = $clog2(MAX_BANNER_BYTES + 1);
  localparam int IDX_W      = 3;
  localparam int LEN_W      = $clog2(KW_MAX + 1);

  // String literals are right justified: the final character sits in bits [7:0]
  localparam logic [KW_MAX*8-1:0] KW_STR [KW_TOTAL] = '{
    "meterpreter",
    "netbus",
    "back orifice",
    "sub7",
    "cobalt strike",
    "empire",
    "pupy",
    "quasar rat"
  };

  localparam logic [LEN_W-1:0] KW_LEN [KW_TOTAL] = '{
    LEN_W'(11), LEN_W'(6), LEN_W'(12), LEN_W'(4),
    LEN_W'(13), LEN_W'(6), LEN_W'(4),  LEN_W'(10)
  };

  typedef struct packed {
    logic [7:0] byte_value;
    logic       byte_present;
    logic       last_byte;
  } bks_item_t;

  typedef logic [7:0] bks_char_t;

  function automatic bks_char_t fold_lower(input bks_char_t c);
    if (c >= 8'h41 && c <= 8'h5a) begin
      return c + 8'd32;
    end
    return c;
  endfunction

endpackage

/* src/bks_in_stage.sv */
// ----------------------------------------------------------------------------
// bks_in_stage: input register
// Captures one stream transfer per cycle unless stalled; holds it until taken.
// ----------------------------------------------------------------------------
module bks_in_stage (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [7:0]         s_axis_tdata,
  input  logic               s_axis_tuser,
  input  logic               s_axis_tlast,
  input  logic               advance,
  output logic               item_vld,
  output bks_pkg::bks_item_t item
);
  import bks_pkg::*;

  // Register is free when empty or when the held item moves on this cycle
  assign s_axis_tready = !item_vld || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_vld <= 1'b0;
    end else if (s_axis_tready) begin
      item_vld <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      item.byte_value   <= s_axis_tdata;
      item.byte_present <= s_axis_tuser;
      item.last_byte    <= s_axis_tlast;
    end
  end

endmodule

/* src/bks_match.sv */
// ----------------------------------------------------------------------------
// bks_match: parallel keyword compare
// Checks every keyword against the current folded byte and the history window.
// ----------------------------------------------------------------------------
module bks_match (
  input  bks_pkg::bks_char_t              cur,
  input  bks_pkg::bks_char_t              hist [bks_pkg::HIST_DEPTH],
  output logic [bks_pkg::KW_TOTAL-1:0]    hit
);
  import bks_pkg::*;

  bks_char_t win [KW_MAX];

  // win[0] is the newest byte, win[i] the byte i positions back
  always_comb begin
    for (int i = 0; i < KW_MAX; i++) begin
      if (i == 0) begin
        win[i] = cur;
      end else if (i <= HIST_DEPTH) begin
        win[i] = hist[(i > 0) ? i - 1 : 0];
      end else begin
        win[i] = 8'h00;
      end
    end
  end

  always_comb begin
    for (int k = 0; k < KW_TOTAL; k++) begin
      hit[k] = (k < KEYWORD_COUNT) && (int'(KW_LEN[k]) <= WINDOW_BYTES) &&
               (KW_LEN[k] != '0);
      for (int i = 0; i < KW_MAX; i++) begin
        if (i < int'(KW_LEN[k]) && win[i] != KW_STR[k][8*i +: 8]) begin
          hit[k] = 1'b0;
        end
      end
    end
  end

endmodule

/* src/banner_keyword_scanner.sv */
// ----------------------------------------------------------------------------
// banner_keyword_scanner: multi keyword search over a byte stream banner
// Folds each byte to lower case, matches eight keywords ending at every byte,
// and reports the lowest matching keyword on the last transfer of a banner.
//
//   port group  dir  tdata / tuser / tlast
//   s_axis      in   tdata[7:0] byte_value, tuser byte_present, tlast last_byte
//   m_axis      out  tdata[0] found, tdata[3:1] word_index, tdata[7:4] zero
//
// One byte per cycle unless a last item waits for the result slot: input
// register, compare and state update, result register.
// Synchronous reset clears all scan state; banners may follow back to back.
// A stalled result holds m_axis; a following last item then waits in the
// input register and holds off every s_axis transfer after it.
// ----------------------------------------------------------------------------
module banner_keyword_scanner (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] byte_value
  input  logic       s_axis_tuser,   // [0] byte_present
  input  logic       s_axis_tlast,
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata    // [0] found, [3:1] word_index, [7:4] zero
);
  import bks_pkg::*;

  logic                item_vld;
  bks_item_t           item;
  logic                advance;

  bks_char_t           hist      [HIST_DEPTH];
  bks_char_t           hist_next [HIST_DEPTH];
  logic [KW_TOTAL-1:0] flags, flags_next, flags_upd;
  logic [CNT_W-1:0]    bytes_seen, bytes_seen_next;
  logic                stopped, stopped_next;

  bks_char_t           cur;
  logic [KW_TOTAL-1:0] hit;
  logic                scan;

  logic                res_found;
  logic [IDX_W-1:0]    res_idx;
  logic                out_found;
  logic [IDX_W-1:0]    out_idx;

  bks_in_stage u_in (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .advance       (advance),
    .item_vld      (item_vld),
    .item          (item)
  );

  assign cur = fold_lower(item.byte_value);

  bks_match u_match (
    .cur  (cur),
    .hist (hist),
    .hit  (hit)
  );

  // Only a last item needs the result slot
  assign advance = item_vld && (!item.last_byte || !m_axis_tvalid || m_axis_tready);

  assign scan = item.byte_present && !stopped &&
                (bytes_seen < CNT_W'(MAX_BANNER_BYTES));

  always_comb begin
    flags_upd       = flags;
    bytes_seen_next = bytes_seen;
    stopped_next    = stopped;
    hist_next       = hist;
    if (scan) begin
      if (item.byte_value == 8'h00) begin
        stopped_next = 1'b1;
      end else begin
        flags_upd       = flags | hit;
        bytes_seen_next = bytes_seen + CNT_W'(1);
        for (int i = HIST_DEPTH - 1; i > 0; i--) begin
          hist_next[i] = hist[i-1];
        end
        hist_next[0] = cur;
      end
    end
    flags_next = flags_upd;
    if (item.last_byte) begin
      flags_next      = '0;
      bytes_seen_next = '0;
      stopped_next    = 1'b0;
      for (int i = 0; i < HIST_DEPTH; i++) begin
        hist_next[i] = 8'h00;
      end
    end
  end

  // Lowest set flag wins
  always_comb begin
    res_found = |flags_upd;
    res_idx   = '0;
    for (int k = KW_TOTAL - 1; k >= 0; k--) begin
      if (flags_upd[k]) begin
        res_idx = IDX_W'(k);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      flags      <= '0;
      bytes_seen <= '0;
      stopped    <= 1'b0;
      for (int i = 0; i < HIST_DEPTH; i++) begin
        hist[i] <= 8'h00;
      end
    end else if (advance) begin
      flags      <= flags_next;
      bytes_seen <= bytes_seen_next;
      stopped    <= stopped_next;
      hist       <= hist_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance && item.last_byte) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && item.last_byte) begin
      out_found <= res_found;
      out_idx   <= res_idx;
    end
  end

  assign m_axis_tdata = {(8 - IDX_W - 1)'(0), out_idx, out_found};

  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    advance && item.last_byte |=> flags == '0 && bytes_seen == '0 && !stopped)
    else $error("scan state not cleared after last item");

  a_result_follows_last: assert property (@(posedge clk) disable iff (rst)
    advance && item.last_byte |=> m_axis_tvalid)
    else $error("no result after last item");

  a_count_limit: assert property (@(posedge clk) disable iff (rst)
    bytes_seen <= CNT_W'(MAX_BANNER_BYTES))
    else $error("byte count past limit");

  a_index_zero_when_none: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !out_found |-> out_idx == '0)
    else $error("nonzero index without a match");

  a_no_advance_into_full: assert property (@(posedge clk) disable iff (rst)
    advance && item.last_byte && m_axis_tvalid |-> m_axis_tready)
    else $error("result overwritten while stalled");

endmodule
